[rtl/core/chacha20_keystream_xor_macros.svh]
// Assertion macros for the ChaCha20 keystream XOR block.
// Included by the modules that carry assertions; no other dependencies.
`ifndef CHACHA20_KEYSTREAM_XOR_MACROS_SVH
`define CHACHA20_KEYSTREAM_XOR_MACROS_SVH
`ifndef SYNTH
`define CC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define CC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/core/cc20_pkg.sv]
// Shared types and constants for the ChaCha20 keystream XOR block.
// No dependencies.
`timescale 1ns / 1ps
package cc20_pkg;
    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;
    localparam int DOUBLE_ROUNDS = 10;
    localparam int BLOCK_BYTES = 64;

    localparam logic [2:0] REG_KEY0 = 3'd0;
    localparam logic [2:0] REG_KEY1 = 3'd1;
    localparam logic [2:0] REG_KEY2 = 3'd2;
    localparam logic [2:0] REG_KEY3 = 3'd3;
    localparam logic [2:0] REG_NONCE_LO = 3'd4;
    localparam logic [2:0] REG_NONCE_HI = 3'd5;
    localparam logic [2:0] REG_INIT_CNT = 3'd6;

    typedef struct packed {
        logic [7:0] data_in;
        logic       last_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data_out;
        logic       last_out;
    } t_out_item;

    // front-to-back queue entry: byte, last marker, message start, and whether a block must be made first
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       start;
        logic       new_block;
    } t_job;

    typedef logic [15:0][31:0] t_state;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        rotl = (v << s) | (v >> (32 - s));
    endfunction

    function automatic logic [127:0] qround(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
        logic [31:0] ta, tb, tc, td;
        ta = a + b; td = rotl(d ^ ta, 16);
        tc = c + td; tb = rotl(b ^ tc, 12);
        ta = ta + tb; td = rotl(td ^ ta, 8);
        tc = tc + td; tb = rotl(tb ^ tc, 7);
        qround = {ta, tb, tc, td};
    endfunction
endpackage

[rtl/core/cc20_front.sv]
// Front end: accepts bytes, tracks message start and block position, queues jobs.
// Depends on cc20_pkg.
`timescale 1ns / 1ps
module cc20_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  cc20_pkg::t_in_item i_item,
    output logic              o_job_valid,
    input  logic              i_job_ready,
    output cc20_pkg::t_job    o_job
);
    import cc20_pkg::*;
    `include "chacha20_keystream_xor_macros.svh"

    localparam int QDEPTH = 4;

    t_job       r_q [QDEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic [5:0] r_pos;
    logic       r_await;
    logic       w_push, w_pop;
    t_job       w_job;

    assign o_ready = (r_cnt != 3'(QDEPTH));
    assign w_push = i_valid && o_ready;
    assign o_job_valid = (r_cnt != 3'd0);
    assign w_pop = o_job_valid && i_job_ready;
    assign o_job = r_q[r_rp];

    always_comb begin
        w_job.data = i_item.data_in;
        w_job.last = i_item.last_in;
        w_job.start = r_await;
        w_job.new_block = r_await || (r_pos == 6'd0);
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
            r_pos <= '0;
            r_await <= 1'b1;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 2'd1;
                // position wraps after byte 63, which forces a new block
                r_pos <= r_await ? 6'd1 : r_pos + 6'd1;
                r_await <= i_item.last_in;
            end
            if (w_pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + 3'(w_push) - 3'(w_pop);
        end
    end

    `CC_ASSERT_IMPL(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= 3'(QDEPTH), "queue overfilled")
    `CC_ASSERT_NEXT(a_last_await, i_clk, i_rst_n, w_push && i_item.last_in, r_await, "no restart after last")
    `CC_ASSERT_IMPL(a_start_new, i_clk, i_rst_n, 1'b1, !w_job.start || w_job.new_block, "start without block")
endmodule

[rtl/core/cc20_back.sv]
// Back end: runs the ChaCha20 rounds (one round per cycle) and XORs queued bytes.
// Depends on cc20_pkg.
`timescale 1ns / 1ps
module cc20_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    output logic                o_job_ready,
    input  cc20_pkg::t_job      i_job,
    input  cc20_pkg::t_state    i_init,
    input  logic [31:0]         i_init_cnt,
    output logic                o_valid,
    input  logic                i_ready,
    output cc20_pkg::t_out_item o_item
);
    import cc20_pkg::*;
    `include "chacha20_keystream_xor_macros.svh"

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;

    logic [1:0]  r_st, n_st;
    logic [4:0]  r_rnd;
    logic [31:0] r_ctr;
    t_state      r_init, r_w, r_ks, w_round, w_seed;
    logic [5:0]  r_pos;
    logic        r_ovalid;
    t_out_item   r_out;
    logic        w_out_free, w_do_byte, w_begin;
    logic [31:0] w_word, w_ctr;
    logic [7:0]  w_ks;

    assign w_out_free = !r_ovalid || i_ready;
    assign w_begin = (r_st == ST_IDLE) && i_job_valid && i_job.new_block;
    assign w_do_byte = (r_st == ST_IDLE) && i_job_valid && !i_job.new_block && w_out_free;
    assign o_job_ready = w_do_byte;
    assign o_valid = r_ovalid;
    assign o_item = r_out;
    assign w_ctr = i_job.start ? i_init_cnt : r_ctr;
    assign w_word = r_ks[r_pos[5:2]];
    assign w_ks = 8'(w_word >> {r_pos[1:0], 3'b000});

    // block input words with the counter in word 12
    always_comb begin
        w_seed = i_init;
        w_seed[12] = w_ctr;
    end

    // column round on even steps, diagonal round on odd steps
    always_comb begin
        w_round = r_w;
        if (!r_rnd[0]) begin
            for (int i = 0; i < 4; i++) begin
                {w_round[i], w_round[4+i], w_round[8+i], w_round[12+i]} =
                    qround(r_w[i], r_w[4+i], r_w[8+i], r_w[12+i]);
            end
        end else begin
            for (int i = 0; i < 4; i++) begin
                {w_round[i], w_round[4+(i+1)%4], w_round[8+(i+2)%4], w_round[12+(i+3)%4]} =
                    qround(r_w[i], r_w[4+(i+1)%4], r_w[8+(i+2)%4], r_w[12+(i+3)%4]);
            end
        end
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: if (w_begin) n_st = ST_RUN;
            ST_RUN:  if (r_rnd == 5'(2 * DOUBLE_ROUNDS)) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_begin) begin
            r_init <= w_seed;
            r_w <= w_seed;
        end else if (r_st == ST_RUN && r_rnd != 5'(2 * DOUBLE_ROUNDS)) begin
            r_w <= w_round;
        end
        if (r_st == ST_RUN && r_rnd == 5'(2 * DOUBLE_ROUNDS)) begin
            for (int i = 0; i < 16; i++) begin
                r_ks[i] <= r_w[i] + r_init[i];
            end
        end
        if (w_do_byte) begin
            r_out.data_out <= i_job.data ^ w_ks;
            r_out.last_out <= i_job.last;
        end
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_rnd <= '0;
            r_ctr <= '0;
            r_pos <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (w_begin) begin
                r_rnd <= '0;
                r_ctr <= w_ctr + 32'd1;
            end else if (r_st == ST_RUN && r_rnd != 5'(2 * DOUBLE_ROUNDS)) begin
                r_rnd <= r_rnd + 5'd1;
            end
            if (r_st == ST_RUN && r_rnd == 5'(2 * DOUBLE_ROUNDS)) begin
                r_pos <= '0;
            end else if (w_do_byte) begin
                r_pos <= r_pos + 6'd1;
            end
            if (w_do_byte) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // bytes leave only between blocks; a finished block restarts the byte position
    `CC_ASSERT_IMPL(a_pop_idle, i_clk, i_rst_n, o_job_ready, r_st == ST_IDLE, "pop while busy")
    `CC_ASSERT_NEXT(a_run_end, i_clk, i_rst_n, r_st == ST_RUN && r_rnd == 5'(2 * DOUBLE_ROUNDS),
        r_st == ST_IDLE && r_pos == 6'd0, "block finish mismatch")
    `CC_ASSERT_IMPL(a_rnd_bound, i_clk, i_rst_n, 1'b1, r_rnd <= 5'(2 * DOUBLE_ROUNDS), "round overrun")
endmodule

[rtl/core/cc20_jobfix.sv]
// Job filter: clears the new-block and start flags on the queue head once its block has been started.
// Depends on cc20_pkg.
`timescale 1ns / 1ps
module cc20_jobfix (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  cc20_pkg::t_job i_job,
    input  logic           i_pop,
    input  logic           i_started,
    output cc20_pkg::t_job o_job
);
    import cc20_pkg::*;

    logic r_served;

    always_comb begin
        o_job = i_job;
        if (r_served) begin
            o_job.new_block = 1'b0;
            o_job.start = 1'b0;
        end
    end

    // hold the served mark until the head byte transfers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_served <= 1'b0;
        end else if (i_pop) begin
            r_served <= 1'b0;
        end else if (i_started && i_valid) begin
            r_served <= 1'b1;
        end
    end
endmodule

[rtl/core/chacha20_keystream_xor.sv]
// ChaCha20 keystream XOR: one byte in, one byte out, valid/ready on both sides.
// Each byte inside a block passes the front queue and the output register; a new block
// first takes a load, twenty rounds at one a cycle, and the final add.
// Bytes wait while a block is built by the single shared round unit.
// Reset: synchronous active low; control and config registers clear, next byte starts a new message.
`timescale 1ns / 1ps
module chacha20_keystream_xor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  cc20_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output cc20_pkg::t_out_item o_item,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [63:0]         i_cfg_data
);
    import cc20_pkg::*;

    logic [63:0] r_key0, r_key1, r_key2, r_key3, r_nlo;
    logic [31:0] r_nhi, r_icnt;
    t_state      w_init;
    logic        w_jvalid, w_jready;
    t_job        w_jraw, w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= '0; r_key1 <= '0; r_key2 <= '0; r_key3 <= '0;
            r_nlo <= '0; r_nhi <= '0; r_icnt <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KEY0:     r_key0 <= i_cfg_data;
                REG_KEY1:     r_key1 <= i_cfg_data;
                REG_KEY2:     r_key2 <= i_cfg_data;
                REG_KEY3:     r_key3 <= i_cfg_data;
                REG_NONCE_LO: r_nlo <= i_cfg_data;
                REG_NONCE_HI: r_nhi <= i_cfg_data[31:0];
                REG_INIT_CNT: r_icnt <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign w_init = {r_nhi, r_nlo[63:32], r_nlo[31:0], 32'd0,
                     r_key3[63:32], r_key3[31:0], r_key2[63:32], r_key2[31:0],
                     r_key1[63:32], r_key1[31:0], r_key0[63:32], r_key0[31:0],
                     SIGMA3, SIGMA2, SIGMA1, SIGMA0};

    cc20_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_item(i_item),
        .o_job_valid(w_jvalid), .i_job_ready(w_jready), .o_job(w_jraw)
    );

    cc20_jobfix u_fix (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_jvalid), .i_job(w_jraw),
        .i_pop(w_jready), .i_started(w_jvalid && w_job.new_block), .o_job(w_job)
    );

    cc20_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(w_jvalid), .o_job_ready(w_jready), .i_job(w_job),
        .i_init(w_init), .i_init_cnt(r_icnt),
        .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item)
    );
endmodule

[verif/chacha20_keystream_xor_checker.sv]
`timescale 1ns / 1ps
// Checker for the ChaCha20 keystream XOR block: mirrors its key, nonce and counter
// registers, predicts each output byte and compares in order. Depends on cc20_pkg.
module chacha20_keystream_xor_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_in_ready,
    input  cc20_pkg::t_in_item  i_item,
    input  logic                i_out_valid,
    input  logic                i_ready,
    input  cc20_pkg::t_out_item i_out_item,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [63:0]         i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);
    import cc20_pkg::*;

    logic [63:0] key_regs [4];
    logic [63:0] nonce_lo_reg;
    logic [31:0] nonce_hi_reg;
    logic [31:0] start_count_reg;
    logic [31:0] blk_count;
    logic [31:0] ks_words [16];
    int          ks_pos;
    logic        msg_start;
    t_out_item   expected_bytes [$];

    assign o_pending = expected_bytes.size();

    function automatic logic [31:0] rot_left(logic [31:0] v, int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // ChaCha quarter round on the working words
    function automatic void mix(ref logic [31:0] w [16], input int a, int b, int c, int d);
        w[a] += w[b]; w[d] = rot_left(w[d] ^ w[a], 16);
        w[c] += w[d]; w[b] = rot_left(w[b] ^ w[c], 12);
        w[a] += w[b]; w[d] = rot_left(w[d] ^ w[a], 8);
        w[c] += w[d]; w[b] = rot_left(w[b] ^ w[c], 7);
    endfunction

    task automatic gen_keystream_block();
        logic [31:0] seed [16];
        logic [31:0] w [16];
        seed[0] = SIGMA0; seed[1] = SIGMA1; seed[2] = SIGMA2; seed[3] = SIGMA3;
        for (int k = 0; k < 4; k++) begin
            seed[4 + 2 * k] = key_regs[k][31:0];
            seed[5 + 2 * k] = key_regs[k][63:32];
        end
        seed[12] = blk_count;
        seed[13] = nonce_lo_reg[31:0];
        seed[14] = nonce_lo_reg[63:32];
        seed[15] = nonce_hi_reg;
        w = seed;
        for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
            mix(w, 0, 4, 8, 12); mix(w, 1, 5, 9, 13);
            mix(w, 2, 6, 10, 14); mix(w, 3, 7, 11, 15);
            mix(w, 0, 5, 10, 15); mix(w, 1, 6, 11, 12);
            mix(w, 2, 7, 8, 13); mix(w, 3, 4, 9, 14);
        end
        for (int k = 0; k < 16; k++) ks_words[k] = w[k] + seed[k];
        blk_count++;
    endtask

    always @(posedge i_clk) begin
        t_out_item exp_item;
        t_out_item got;
        logic [31:0] word;
        if (!i_rst_n) begin
            foreach (key_regs[k]) key_regs[k] <= '0;
            nonce_lo_reg <= '0;
            nonce_hi_reg <= '0;
            start_count_reg <= '0;
            blk_count = '0;
            ks_pos = BLOCK_BYTES;
            msg_start = 1'b1;
            o_fail_count <= 0;
            expected_bytes.delete();
        end else begin
            if (i_valid && i_in_ready) begin
                if (msg_start) begin
                    blk_count = start_count_reg;
                    ks_pos = BLOCK_BYTES;
                    msg_start = 1'b0;
                end
                if (ks_pos >= BLOCK_BYTES) begin
                    gen_keystream_block();
                    ks_pos = 0;
                end
                word = ks_words[ks_pos / 4];
                exp_item.data_out = i_item.data_in ^ word[(ks_pos % 4) * 8 +: 8];
                exp_item.last_out = i_item.last_in;
                ks_pos++;
                if (i_item.last_in) msg_start = 1'b1;
                expected_bytes.push_back(exp_item);
            end
            if (i_out_valid && i_ready) begin
                got = i_out_item;
                if (expected_bytes.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected output byte %h last %b", got.data_out,
                                 got.last_out);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_item = expected_bytes.pop_front();
                    if (got !== exp_item) begin
                        if (o_fail_count < 10)
                            $display("mismatch: data exp %h got %h, last exp %b got %b",
                                     exp_item.data_out, got.data_out,
                                     exp_item.last_out, got.last_out);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_KEY0:     key_regs[0] <= i_cfg_data;
                    REG_KEY1:     key_regs[1] <= i_cfg_data;
                    REG_KEY2:     key_regs[2] <= i_cfg_data;
                    REG_KEY3:     key_regs[3] <= i_cfg_data;
                    REG_NONCE_LO: nonce_lo_reg <= i_cfg_data;
                    REG_NONCE_HI: nonce_hi_reg <= i_cfg_data[31:0];
                    REG_INIT_CNT: start_count_reg <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

[verif/tb_chacha20_keystream_xor.sv]
`timescale 1ns / 1ps
// Top of the ChaCha20 keystream XOR testbench: clock, reset, byte stimulus and register
// writes. Depends on cc20_pkg, chacha20_keystream_xor and chacha20_keystream_xor_checker.
module tb_chacha20_keystream_xor;
    import cc20_pkg::*;

    localparam int STALL_LIMIT = 20000;
    // index past the last register, must be ignored
    localparam logic [2:0] REG_UNUSED = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_item    in_item = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_item;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [63:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    chacha20_keystream_xor dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .o_ready(in_ready), .i_item(in_item),
        .o_valid(out_valid), .i_ready(out_ready), .o_item(out_item),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    chacha20_keystream_xor_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .i_in_ready(in_ready), .i_item(in_item),
        .i_out_valid(out_valid), .i_ready(out_ready), .i_out_item(out_item),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // watchdog: count cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog expired");
            $display("** chacha20_keystream_xor: FAILED **");
            $finish;
        end
    end

    // output side: random stalls per byte, some stretches without
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            out_ready <= 1'b1;
            @(posedge i_clk iff out_valid);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (gap != 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // valid stays up between back-to-back bytes; drain drops it after the last one
    task automatic send_byte(input logic [7:0] data, input logic last, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= '{data_in: data, last_in: last};
        @(posedge i_clk iff in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic load_all(input logic [63:0] fill, input logic [31:0] ctr);
        write_reg(REG_KEY0, fill);
        write_reg(REG_KEY1, ~fill);
        write_reg(REG_KEY2, {fill[31:0], fill[63:32]});
        write_reg(REG_KEY3, fill ^ 64'h0123_4567_89ab_cdef);
        write_reg(REG_NONCE_LO, ~fill);
        write_reg(REG_NONCE_HI, {$urandom, fill[31:0]});
        write_reg(REG_INIT_CNT, {$urandom, ctr});
    endtask

    task automatic send_message(input int len, input bit no_gap);
        for (int k = 0; k < len; k++)
            send_byte(8'($urandom), k == len - 1, no_gap);
    endtask

    initial begin
        int len;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-zero key and counter, a few bytes crossing into a second block
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'hff, 1'b0, 1'b0);
        send_message(66, 1'b0);
        drain();
        // all-ones fill pattern (some registers get its inverse); counter wraps from its top value into zero
        load_all('1, 32'hffff_ffff);
        write_reg(REG_UNUSED, 64'h5a5a);
        send_message(70, 1'b1);
        send_byte(8'h80, 1'b1, 1'b0);
        drain();
        // single-byte messages restart the counter each time
        load_all(64'h0706_0504_0302_0100, 32'd1);
        for (int k = 0; k < 4; k++) send_byte(8'($urandom), 1'b1, 1'b0);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            load_all({$urandom, $urandom}, (ph % 2) ? 32'hffff_fffe : $urandom);
            for (int m = 0; m < 6; m++) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 140)
                                                  : $urandom_range(1, 20);
                send_message(len, $urandom_range(0, 3) == 0);
            end
            drain();
        end
        if (fail_count == 0)
            $display("** chacha20_keystream_xor: PASSED **");
        else
            $display("** chacha20_keystream_xor: FAILED **");
        $finish;
    end
endmodule
